[rtl/core/blg_pkg.sv]
// Shared constants, codes and helpers for the Bresenham line generator.
// No dependencies; used by every module of the block.
package blg_pkg;

  // Coordinate width used when the top level is not overridden.
  localparam int COORD_BITS_DEFAULT = 8;

  // Limit registers are 8 bits wide whatever the coordinate width.
  localparam int CFG_BITS = 8;
  localparam logic [CFG_BITS-1:0] MAX_COLUMN_RESET = 8'd131;
  localparam logic [CFG_BITS-1:0] MAX_ROW_RESET    = 8'd175;

  // Register index codes, taken from paddr[2].
  localparam logic REG_MAX_COLUMN = 1'b0;
  localparam logic REG_MAX_ROW    = 1'b1;

  // Request kinds carried on s_tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Width of one packed command: opcode, four coordinates, color,
  // four flags and two doubled deltas.
  function automatic int cmd_width(input int cb);
    return 6 * cb + 23;
  endfunction

endpackage

[rtl/core/blg_front.sv]
// Front end: accepts requests, classifies them and does the line setup.
// Depends on blg_pkg; feeds blg_queue.
module blg_front #(
  parameter int COORD_BITS = blg_pkg::COORD_BITS_DEFAULT,
  localparam int CMD_W = blg_pkg::cmd_width(COORD_BITS),
  localparam int IN_W  = ((4 * COORD_BITS + 16 + 7) / 8) * 8
) (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [IN_W-1:0]              s_tdata,
  input  logic                         s_tuser,
  input  logic [blg_pkg::CFG_BITS-1:0] max_column,
  input  logic [blg_pkg::CFG_BITS-1:0] max_row,
  input  blg_pkg::q_status_t           q_status,
  output logic                         push,
  output logic [CMD_W-1:0]             cmd
);

  localparam int CB    = COORD_BITS;
  localparam int CMP_W = (CB > blg_pkg::CFG_BITS) ? CB : blg_pkg::CFG_BITS;

  typedef struct packed {
    logic          op;
    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
    logic [CB-1:0] ex;
    logic [CB-1:0] ey;
    logic [15:0]   color;
    logic          range_flag;
    logic          dir_x_neg;
    logic          dir_y_neg;
    logic          x_major;
    logic [CB:0]   twice_dx;
    logic [CB:0]   twice_dy;
  } cmd_t;

  cmd_t          c;
  logic [CB-1:0] adx;
  logic [CB-1:0] ady;

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    c.op    = s_tuser;
    c.sx    = s_tdata[CB-1:0];
    c.sy    = s_tdata[2*CB-1:CB];
    c.ex    = s_tdata[3*CB-1:2*CB];
    c.ey    = s_tdata[4*CB-1:3*CB];
    c.color = s_tdata[4*CB+15:4*CB];

    c.range_flag = (CMP_W'(c.sx) > CMP_W'(max_column)) ||
                   (CMP_W'(c.ex) > CMP_W'(max_column)) ||
                   (CMP_W'(c.sy) > CMP_W'(max_row)) ||
                   (CMP_W'(c.ey) > CMP_W'(max_row));

    c.dir_x_neg = c.ex < c.sx;
    c.dir_y_neg = c.ey < c.sy;
    adx = c.dir_x_neg ? (c.sx - c.ex) : (c.ex - c.sx);
    ady = c.dir_y_neg ? (c.sy - c.ey) : (c.ey - c.sy);
    c.twice_dx = {adx, 1'b0};
    c.twice_dy = {ady, 1'b0};
    c.x_major  = adx > ady;
  end

  assign cmd = c;

endmodule

[rtl/core/blg_queue.sv]
// Short command queue that decouples the front end from the stepper.
// Depends on blg_pkg for its depth and status type.
module blg_queue #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   wr_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   rd_data,
  output blg_pkg::q_status_t status
);

  localparam int DEPTH = blg_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign status.full  = count == CW'(DEPTH);
  assign status.empty = count == '0;
  assign rd_data      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_data;
    end
  end

endmodule

[rtl/core/blg_back.sv]
// Back end: holds the line state, runs one Bresenham step per command
// and keeps the output register. Depends on blg_pkg; fed by blg_queue.
module blg_back #(
  parameter int COORD_BITS = blg_pkg::COORD_BITS_DEFAULT,
  localparam int CMD_W = blg_pkg::cmd_width(COORD_BITS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  blg_pkg::q_status_t    q_status,
  input  logic [CMD_W-1:0]      cmd,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic                  m_tlast,
  output logic                  m_tuser,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [15:0]           out_color
);

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 3;

  typedef struct packed {
    logic          op;
    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
    logic [CB-1:0] ex;
    logic [CB-1:0] ey;
    logic [15:0]   color;
    logic          range_flag;
    logic          dir_x_neg;
    logic          dir_y_neg;
    logic          x_major;
    logic [CB:0]   twice_dx;
    logic [CB:0]   twice_dy;
  } cmd_t;

  cmd_t c;

  // Line state.
  logic [CB-1:0]        cur_x;
  logic [CB-1:0]        cur_y;
  logic [CB-1:0]        target_x;
  logic [CB-1:0]        target_y;
  logic signed [EW-1:0] error_term;
  logic [CB:0]          twice_dx;
  logic [CB:0]          twice_dy;
  logic                 dir_x_negative;
  logic                 dir_y_negative;
  logic                 x_major;
  logic                 line_active;
  logic [15:0]          line_color;
  logic                 range_flag;

  logic                 out_free;
  logic                 is_load;
  logic signed [EW-1:0] load_error;
  logic                 load_done;
  logic signed [EW-1:0] tdx_s;
  logic signed [EW-1:0] tdy_s;
  logic signed [EW-1:0] err_major;
  logic signed [EW-1:0] err_minor;
  logic signed [EW-1:0] err_dec;
  logic signed [EW-1:0] step_error;
  logic                 err_ge0;
  logic [CB-1:0]        moved_x;
  logic [CB-1:0]        moved_y;
  logic [CB-1:0]        step_x;
  logic [CB-1:0]        step_y;
  logic                 step_done;

  assign c        = cmd_t'(cmd);
  assign out_free = !m_tvalid || m_tready;
  assign pop      = !q_status.empty && out_free;
  assign is_load  = c.op == blg_pkg::OP_LOAD;

  // Setup of a new line: initial error term and the zero-length test.
  always_comb begin
    if (c.x_major) begin
      load_error = signed'(EW'(c.twice_dy)) - signed'(EW'(c.twice_dx >> 1));
      load_done  = c.sx == c.ex;
    end else begin
      load_error = signed'(EW'(c.twice_dx)) - signed'(EW'(c.twice_dy >> 1));
      load_done  = c.sy == c.ey;
    end
  end

  // One step along the active line.
  always_comb begin
    tdx_s      = signed'(EW'(twice_dx));
    tdy_s      = signed'(EW'(twice_dy));
    err_major  = x_major ? tdx_s : tdy_s;
    err_minor  = x_major ? tdy_s : tdx_s;
    err_ge0    = !error_term[EW-1];
    err_dec    = err_ge0 ? (error_term - err_major) : error_term;
    step_error = err_dec + err_minor;
    moved_x    = dir_x_negative ? (cur_x - 1'b1) : (cur_x + 1'b1);
    moved_y    = dir_y_negative ? (cur_y - 1'b1) : (cur_y + 1'b1);
    if (x_major) begin
      step_x    = moved_x;
      step_y    = err_ge0 ? moved_y : cur_y;
      step_done = moved_x == target_x;
    end else begin
      step_x    = err_ge0 ? moved_x : cur_x;
      step_y    = moved_y;
      step_done = moved_y == target_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        if (is_load) begin
          line_active <= !load_done;
          m_tvalid    <= 1'b1;
        end else if (line_active) begin
          line_active <= !step_done;
          m_tvalid    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (is_load) begin
        cur_x          <= c.sx;
        cur_y          <= c.sy;
        target_x       <= c.ex;
        target_y       <= c.ey;
        error_term     <= load_error;
        twice_dx       <= c.twice_dx;
        twice_dy       <= c.twice_dy;
        dir_x_negative <= c.dir_x_neg;
        dir_y_negative <= c.dir_y_neg;
        x_major        <= c.x_major;
        line_color     <= c.color;
        range_flag     <= c.range_flag;
        pixel_x        <= c.sx;
        pixel_y        <= c.sy;
        out_color      <= c.color;
        m_tlast        <= load_done;
        m_tuser        <= c.range_flag;
      end else if (line_active) begin
        cur_x      <= step_x;
        cur_y      <= step_y;
        error_term <= step_error;
        pixel_x    <= step_x;
        pixel_y    <= step_y;
        out_color  <= line_color;
        m_tlast    <= step_done;
        m_tuser    <= range_flag;
      end
    end
  end

endmodule

[rtl/core/bresenham_line_generator_unit.sv]
// Top level of the Bresenham line generator: request port, limit registers,
// front end, command queue and stepper. Depends on blg_pkg, blg_front,
// blg_queue and blg_back.
//
// Usage. Requests arrive on the s_ channel. s_tuser selects the kind: a load
// (OP_LOAD) carries start_x, start_y, end_x, end_y and pixel_color in s_tdata
// and emits the line's start pixel; a step (OP_STEP) emits the next pixel of
// the active line, or nothing when no line is active. Pixels leave on the m_
// channel; m_tlast marks the endpoint and m_tuser flags a line whose endpoints
// exceeded max_column or max_row at its load. The limits are written through
// the APB port (max_column at address 0, max_row at address 4) while idle.
// A request accepted at a clock edge is written into the queue; its pixel is
// registered in the output register, with m_tvalid set, once the stepper pops it.
// Throughput is one request per clock while the receiver keeps up: each step is
// computed combinationally in the stepper, and the two-entry queue keeps accepting
// while a finished pixel waits in the output register. When the receiver stalls,
// the pixel holds, the queue fills and s_tready drops once it is full.
// Reset empties the queue, drops any line and any pending pixel, and restores
// the limits to 131 and 175.
module bresenham_line_generator_unit #(
  parameter int COORD_BITS = blg_pkg::COORD_BITS_DEFAULT,
  localparam int IN_W  = ((4 * COORD_BITS + 16 + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + 16 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // Request channel.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // start_x, start_y, end_x, end_y, pixel_color
  input  logic             s_tuser,  // opcode
  // Pixel channel.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // pixel_x, pixel_y, out_color
  output logic             m_tlast,  // last
  output logic             m_tuser,  // out_of_range
  // Register port.
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CMD_W = blg_pkg::cmd_width(COORD_BITS);

  logic [blg_pkg::CFG_BITS-1:0] max_column;
  logic [blg_pkg::CFG_BITS-1:0] max_row;
  logic                         reg_write;

  logic                         push;
  logic                         pop;
  logic [CMD_W-1:0]             cmd_in;
  logic [CMD_W-1:0]             cmd_out;
  blg_pkg::q_status_t           q_status;

  logic [COORD_BITS-1:0]        pixel_x;
  logic [COORD_BITS-1:0]        pixel_y;
  logic [15:0]                  out_color;

  // The register port never waits. paddr[2] picks the register.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_column <= blg_pkg::MAX_COLUMN_RESET;
      max_row    <= blg_pkg::MAX_ROW_RESET;
    end else if (reg_write) begin
      unique case (paddr[2])
        blg_pkg::REG_MAX_COLUMN: max_column <= pwdata[blg_pkg::CFG_BITS-1:0];
        blg_pkg::REG_MAX_ROW:    max_row    <= pwdata[blg_pkg::CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      blg_pkg::REG_MAX_COLUMN: prdata = 32'(max_column);
      blg_pkg::REG_MAX_ROW:    prdata = 32'(max_row);
      default:                 prdata = '0;
    endcase
  end

  // The front end decodes each request and computes the deltas, directions,
  // major axis and range flag before it enters the queue.
  blg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .max_column (max_column),
    .max_row    (max_row),
    .q_status   (q_status),
    .push       (push),
    .cmd        (cmd_in)
  );

  blg_queue #(.WIDTH(CMD_W)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (cmd_in),
    .pop     (pop),
    .rd_data (cmd_out),
    .status  (q_status)
  );

  // The stepper takes one command per cycle whenever its output register
  // is free or being emptied in the same cycle.
  blg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .cmd       (cmd_out),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .out_color (out_color)
  );

  // Pad bits above the fields are zero.
  assign m_tdata = OUT_W'({out_color, pixel_y, pixel_x});

endmodule

[rtl/core/blg_checker.sv]
// Port-level checks for the Bresenham line generator, bound to its top level.
// Depends on blg_pkg and bresenham_line_generator_unit.
module blg_checker #(
  parameter int COORD_BITS = blg_pkg::COORD_BITS_DEFAULT,
  localparam int IN_W  = ((4 * COORD_BITS + 16 + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + 16 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast,
  input logic             m_tuser,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic [2:0]       paddr,
  input logic [31:0]      pwdata,
  input logic [31:0]      prdata,
  input logic             pready
);

  // No pixel is pending right after reset.
  a_reset_clears_output: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("pixel pending after reset");

  // A stalled pixel keeps its value.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=>
      m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    else $error("pixel changed while stalled");

  // A written limit reads back in the following cycle.
  a_column_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == blg_pkg::REG_MAX_COLUMN |=>
      !(paddr[2] == blg_pkg::REG_MAX_COLUMN) ||
      prdata[blg_pkg::CFG_BITS-1:0] == $past(pwdata[blg_pkg::CFG_BITS-1:0]))
    else $error("max_column readback mismatch");

  a_row_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == blg_pkg::REG_MAX_ROW |=>
      !(paddr[2] == blg_pkg::REG_MAX_ROW) ||
      prdata[blg_pkg::CFG_BITS-1:0] == $past(pwdata[blg_pkg::CFG_BITS-1:0]))
    else $error("max_row readback mismatch");

endmodule

bind bresenham_line_generator_unit blg_checker #(.COORD_BITS(COORD_BITS)) u_blg_checker (.*);

[tb/sv/bresenham_line_generator_unit_test.sv]
// Self-checking testbench for bresenham_line_generator_unit: random line requests
// checked pixel by pixel against a built-in rasterizer, with random stalls.
// Depends on blg_pkg and the RTL of the line generator; nothing else.
module bresenham_line_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 250000;
  localparam int MAX_REPORTS = 10;

  // One request as it travels on the s_ channel.
  typedef struct packed {
    logic        op;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [15:0] color;
  } line_req_t;

  // One pixel as it leaves on the m_ channel.
  typedef struct packed {
    logic [7:0]  px;
    logic [7:0]  py;
    logic [15:0] color;
    logic        is_last;
    logic        oor;
  } pixel_t;

  // Rasterizer state, kept in step with the block.
  typedef struct {
    logic [7:0]  cx, cy, tx, ty;
    int          err, ddx, ddy;
    bit          neg_x, neg_y, x_major, active, oor;
    logic [15:0] color;
  } raster_state_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // start_x, start_y, end_x, end_y, pixel_color
  logic        s_tuser = 1'b0; // opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // pixel_x, pixel_y, out_color
  logic        m_tlast;        // last
  logic        m_tuser;        // out_of_range
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bresenham_line_generator_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Requests waiting for the driver, and pixels the rasterizer says must come.
  line_req_t     pending_reqs[$];
  pixel_t        pixels_due[$];
  raster_state_t raster;
  logic [7:0]    lim_col;
  logic [7:0]    lim_row;

  int  mismatches = 0;
  int  cycle_count = 0;
  int  gen_pixels = 0;     // pixels the generated requests should produce
  int  idle_pct = 0;       // chance per cycle that an idle burst starts
  bit  quiet = 1'b0;       // no idling at all in the closing part of the run

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing pixel ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Advance the rasterizer by one accepted request. Returns 1 when the
  // request produces a pixel, which is then written to px.
  function automatic bit rasterize(input line_req_t rq, output pixel_t px);
    bit done;
    px = '0;
    if (rq.op == blg_pkg::OP_LOAD) begin
      raster.oor = (rq.sx > lim_col) || (rq.ex > lim_col) ||
                   (rq.sy > lim_row) || (rq.ey > lim_row);
      raster.color = rq.color;
      raster.neg_x = rq.ex < rq.sx;
      raster.neg_y = rq.ey < rq.sy;
      raster.ddx = 2 * (raster.neg_x ? int'(rq.sx) - int'(rq.ex) : int'(rq.ex) - int'(rq.sx));
      raster.ddy = 2 * (raster.neg_y ? int'(rq.sy) - int'(rq.ey) : int'(rq.ey) - int'(rq.sy));
      // Ties go to the y axis: x leads only on a strictly larger delta.
      raster.x_major = raster.ddx > raster.ddy;
      raster.err = raster.x_major ? raster.ddy - raster.ddx / 2 : raster.ddx - raster.ddy / 2;
      raster.cx = rq.sx;
      raster.cy = rq.sy;
      raster.tx = rq.ex;
      raster.ty = rq.ey;
      done = raster.x_major ? (raster.cx == raster.tx) : (raster.cy == raster.ty);
      raster.active = !done;
    end else begin
      // A step with no line in progress is swallowed without a pixel.
      if (!raster.active) return 1'b0;
      if (raster.x_major) begin
        if (raster.err >= 0) begin
          raster.cy = raster.neg_y ? raster.cy - 8'd1 : raster.cy + 8'd1;
          raster.err -= raster.ddx;
        end
        raster.cx = raster.neg_x ? raster.cx - 8'd1 : raster.cx + 8'd1;
        raster.err += raster.ddy;
        raster.active = raster.cx != raster.tx;
      end else begin
        if (raster.err >= 0) begin
          raster.cx = raster.neg_x ? raster.cx - 8'd1 : raster.cx + 8'd1;
          raster.err -= raster.ddy;
        end
        raster.cy = raster.neg_y ? raster.cy - 8'd1 : raster.cy + 8'd1;
        raster.err += raster.ddx;
        raster.active = raster.cy != raster.ty;
      end
      done = !raster.active;
    end
    px.px = raster.cx;
    px.py = raster.cy;
    px.color = raster.color;
    px.is_last = done;
    px.oor = raster.oor;
    return 1'b1;
  endfunction

  // Request driver. A new request is presented only once the previous one
  // has been taken, so tvalid never drops while a request is on offer.
  int        src_gap = 0;
  line_req_t drv_req;
  pixel_t    due_px;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (rasterize(drv_req, due_px)) pixels_due.push_back(due_px);
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
          src_gap = $urandom_range(1, 18) - 1;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          drv_req = pending_reqs.pop_front();
          s_tdata <= {drv_req.color, drv_req.ey, drv_req.ex, drv_req.sy, drv_req.sx};
          s_tuser <= drv_req.op;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor and receiver back-pressure.
  int     snk_hold = 0;
  pixel_t got_px;
  pixel_t want_px;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_px = {m_tdata[7:0], m_tdata[15:8], m_tdata[31:16], m_tlast, m_tuser};
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b oor=%b", $realtime,
                   got_px.px, got_px.py, got_px.color, got_px.is_last, got_px.oor);
      end else begin
        want_px = pixels_due.pop_front();
        if (got_px !== want_px) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: pixel mismatch: expected x=%0d y=%0d color=%h last=%b oor=%b, %s",
                     $realtime, want_px.px, want_px.py, want_px.color, want_px.is_last,
                     want_px.oor, $sformatf("got x=%0d y=%0d color=%h last=%b oor=%b",
                     got_px.px, got_px.py, got_px.color, got_px.is_last, got_px.oor));
        end
      end
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (snk_hold > 0) begin
      snk_hold--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      snk_hold = $urandom_range(1, 18) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Write one limit register through the APB port; only called while idle.
  task automatic write_limit(input logic idx, input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    // Upper data bits carry noise; the register keeps only the low byte.
    pwdata <= ($urandom() & 32'hFFFF_FF00) | {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == blg_pkg::REG_MAX_COLUMN) lim_col = value;
    else lim_row = value;
  endtask

  task automatic push_step();
    line_req_t rq;
    // Steps carry random data that the block must ignore.
    rq = {blg_pkg::OP_STEP, 48'($urandom()) ^ {$urandom(), 16'h0}};
    rq.op = blg_pkg::OP_STEP;
    pending_reqs.push_back(rq);
  endtask

  // Queue a load followed by a number of steps, and count the pixels due.
  task automatic push_line(input logic [7:0] sx, input logic [7:0] sy,
                           input logic [7:0] ex, input logic [7:0] ey,
                           input logic [15:0] color, input int steps);
    line_req_t rq;
    int        span_x;
    int        span_y;
    int        span;
    rq = '{op: blg_pkg::OP_LOAD, sx: sx, sy: sy, ex: ex, ey: ey, color: color};
    pending_reqs.push_back(rq);
    span_x = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
    span_y = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
    span = (span_x > span_y) ? span_x : span_y;
    gen_pixels += 1 + ((steps < span) ? steps : span);
    repeat (steps) push_step();
  endtask

  // Endpoint near a start point, clamped to the coordinate range.
  function automatic logic [7:0] near_coord(input logic [7:0] c);
    int t;
    t = int'(c) + int'($urandom_range(0, 24)) - 12;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  task automatic push_random_line();
    logic [7:0] sx, sy, ex, ey;
    int         span;
    int         span_y;
    int         pick;
    sx = 8'($urandom_range(0, 255));
    sy = 8'($urandom_range(0, 255));
    // Most lines are short; a few take endpoints anywhere in the coordinate range.
    if ($urandom_range(0, 99) < 6) begin
      ex = 8'($urandom_range(0, 255));
      ey = 8'($urandom_range(0, 255));
    end else begin
      ex = near_coord(sx);
      ey = near_coord(sy);
    end
    span = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
    span_y = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
    if (span_y > span) span = span_y;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      push_line(sx, sy, ex, ey, 16'($urandom()), $urandom_range(0, span)); // cut short
    else if (pick < 20)
      push_line(sx, sy, ex, ey, 16'($urandom()), span + $urandom_range(1, 3)); // idle steps
    else
      push_line(sx, sy, ex, ey, 16'($urandom()), span);
  endtask

  // Wait until every request has been taken and every pixel has arrived,
  // then give the pipeline time to finish any step that makes no pixel.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || pixels_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    raster = '{cx: 0, cy: 0, tx: 0, ty: 0, err: 0, ddx: 0, ddy: 0, neg_x: 0, neg_y: 0,
               x_major: 0, active: 0, oor: 0, color: 0};
    lim_col = blg_pkg::MAX_COLUMN_RESET;
    lim_row = blg_pkg::MAX_ROW_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset limits of 131 and 175.
    idle_pct = 15;
    push_step();                                 // step with no line: no pixel
    push_line(0, 0, 0, 0, 16'h0000, 1);          // zero-length line, then an idle step
    push_line(255, 255, 252, 255, 16'hFFFF, 3);  // leftward, out of range
    push_line(0, 0, 3, 3, 16'h1234, 3);          // equal deltas: y leads
    push_line(10, 255, 12, 250, 16'hA5A5, 5);    // steep and upward
    push_line(131, 175, 131, 175, 16'h8001, 0);  // exactly on the limits
    push_line(132, 176, 130, 174, 16'h7FFE, 1);  // just past the limits, then abandoned
    push_line(5, 5, 9, 6, 16'h0F0F, 5);          // shallow line run to its end and past
    wait_drained();

    // Random phases, each under its own pair of limits.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_limit(blg_pkg::REG_MAX_COLUMN, 8'd0);
          write_limit(blg_pkg::REG_MAX_ROW, 8'd0);
        end
        2: begin
          write_limit(blg_pkg::REG_MAX_COLUMN, 8'd255);
          write_limit(blg_pkg::REG_MAX_ROW, 8'd255);
        end
        3: begin
          write_limit(blg_pkg::REG_MAX_COLUMN, 8'd255);
          write_limit(blg_pkg::REG_MAX_ROW, 8'd0);
        end
        default: begin
          write_limit(blg_pkg::REG_MAX_COLUMN, 8'($urandom_range(0, 255)));
          write_limit(blg_pkg::REG_MAX_ROW, 8'($urandom_range(0, 255)));
        end
      endcase
      idle_pct = (phase == 4) ? 0 : $urandom_range(5, 30);
      quiet = (phase == 5);
      gen_pixels = 0;
      // The last line of a phase can take the pixel count past the threshold.
      while (gen_pixels < 120) push_random_line();
      wait_drained();
    end

    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
